[rtl/core/wprs_pkg.sv]
// ----------------------------------------------------------------------------
// Wireless pad receiver slots package
// Shared types, message codes and helper functions of the slot tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package wprs_pkg;

    localparam int SlotBits = 3;
    localparam int SlotCount = 8;

    localparam logic [7:0] AxisLow = 8'h81;
    localparam logic [7:0] AxisHigh = 8'h7f;
    localparam logic [7:0] GamepadDevice = 8'h02;
    localparam logic [5:0] ReplyBytes = 6'd6;
    localparam logic [5:0] InputMinBytes = 6'd13;
    localparam logic [5:0] InfoMinBytes = 6'd3;
    localparam logic [5:0] InfoSetMinBytes = 6'd4;
    localparam logic [5:0] ZeroMinBytes = 6'd2;

    localparam logic [2:0] MsgInput = 3'd1;
    localparam logic [2:0] MsgInfo = 3'd3;
    localparam logic [2:0] MsgZeroState = 3'd6;

    localparam logic [7:0] SubNewSession = 8'h01;
    localparam logic [7:0] SubMarkGamepad = 8'h04;
    localparam logic [7:0] SubRelease = 8'h05;
    localparam logic [7:0] SubTypeA = 8'h0a;
    localparam logic [7:0] SubTypeB = 8'h0b;
    localparam logic [7:0] SubTypeC = 8'h0c;

    typedef enum logic [1:0] {
        OP_RECEIVED = 2'd0,
        OP_OUT_DONE = 2'd1,
        OP_POLL = 2'd2,
        OP_DISCONNECT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_PAD = 2'd0,
        KIND_RELEASED = 2'd1,
        KIND_ACTIVATE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CMD_INPUT = 3'd0,
        CMD_INFO_SET = 3'd1,
        CMD_MARK_PAD = 3'd2,
        CMD_RELEASE = 3'd3,
        CMD_ZERO_STATE = 3'd4,
        CMD_OUT_DONE = 3'd5,
        CMD_POLL = 3'd6,
        CMD_DISCONNECT = 3'd7
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
        logic [SlotBits-1:0] slot;
        logic [7:0] action;
        logic [2:0] system;
        logic [3:0] dpad;
        logic flag_a;
        logic flag_b;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic [SlotBits-1:0] slot;
        logic [7:0] action;
        logic [2:0] system;
        logic [3:0] dpad;
        logic last;
    } result_t;

    function automatic logic [SlotBits-1:0] lowest_slot(input logic [SlotCount-1:0] mask);
        logic [SlotBits-1:0] idx;
        idx = '0;
        for (int i = SlotCount - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = SlotBits'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[rtl/core/wprs_front.sv]
// ----------------------------------------------------------------------------
// Wireless pad receiver slots front end
// Checks lengths, decodes message types and turns each event into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module wprs_front
    import wprs_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = 27
) (
    input  wire logic [1:0] op,
    input  wire logic [5:0] length,
    input  wire logic [7:0] byte0,
    input  wire logic [7:0] byte1,
    input  wire logic [7:0] byte2,
    input  wire logic [7:0] byte3,
    input  wire logic [7:0] byte4,
    input  wire logic [7:0] x_axis,
    input  wire logic [7:0] y_axis,
    input  wire logic [7:0] face_bits,
    input  wire logic [7:0] system_bits,
    input  wire logic       transfer_ok,
    output cmd_t            cmd,
    output logic            keep
);

    localparam logic [5:0] MaxLen = 6'(MAX_REPORT_BYTES);

    logic       len_ok;
    logic [2:0] msg_type;

    assign len_ok = transfer_ok && (length != 6'd0) && (length <= MaxLen);
    assign msg_type = byte0[2:0];

    always_comb begin
        cmd = '0;
        cmd.code = CMD_POLL;
        cmd.slot = byte1[2:0];
        keep = 1'b0;
        unique case (op_t'(op))
            OP_RECEIVED: begin
                if (len_ok) begin
                    priority if (msg_type == MsgInput) begin
                        cmd.code = CMD_INPUT;
                        cmd.slot = byte4[2:0];
                        cmd.action = face_bits;
                        cmd.system = system_bits[2:0];
                        cmd.dpad = {y_axis == AxisHigh, y_axis == AxisLow,
                                    x_axis == AxisHigh, x_axis == AxisLow};
                        keep = (length >= InputMinBytes);
                    end else if (msg_type == MsgInfo) begin
                        if (length >= InfoMinBytes) begin
                            priority if (byte2 == SubNewSession || byte2 == SubTypeA ||
                                         byte2 == SubTypeB || byte2 == SubTypeC) begin
                                cmd.code = CMD_INFO_SET;
                                cmd.flag_a = (byte2 == SubNewSession);
                                cmd.flag_b = (byte3 == GamepadDevice);
                                keep = (length >= InfoSetMinBytes);
                            end else if (byte2 == SubMarkGamepad) begin
                                cmd.code = CMD_MARK_PAD;
                                keep = 1'b1;
                            end else if (byte2 == SubRelease) begin
                                cmd.code = CMD_RELEASE;
                                keep = 1'b1;
                            end else begin
                                keep = 1'b0;
                            end
                        end
                    end else if (msg_type == MsgZeroState) begin
                        cmd.code = CMD_ZERO_STATE;
                        keep = (length >= ZeroMinBytes);
                    end else begin
                        keep = 1'b0;
                    end
                end
            end
            OP_OUT_DONE: begin
                cmd.code = CMD_OUT_DONE;
                cmd.flag_a = !transfer_ok || (length != ReplyBytes);
                keep = 1'b1;
            end
            OP_POLL: begin
                cmd.code = CMD_POLL;
                keep = 1'b1;
            end
            OP_DISCONNECT: begin
                cmd.code = CMD_DISCONNECT;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/wprs_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// Wireless pad receiver slots command queue
// Four-entry queue that decouples the front end from the slot state engine.
// ----------------------------------------------------------------------------
`default_nettype none

module wprs_cmd_fifo
    import wprs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head_cmd
);

    localparam int Depth = 4;
    localparam int PtrBits = $clog2(Depth);

    cmd_t               entry_reg [Depth];
    logic [PtrBits-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrBits-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrBits:0]   count_reg, count_next;

    assign full = (count_reg == (PtrBits+1)'(Depth));
    assign not_empty = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PtrBits'(push);
        rd_ptr_next = rd_ptr_reg + PtrBits'(pop);
        count_next = count_reg + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/wprs_back.sv]
// ----------------------------------------------------------------------------
// Wireless pad receiver slots state engine
// Holds the slot state, executes queued commands and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wprs_back
    import wprs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    output logic      res_valid,
    output result_t   res,
    input  wire logic res_ready
);

    logic [SlotCount-1:0] is_gamepad_reg, is_gamepad_next;
    logic [SlotCount-1:0] reported_reg, reported_next;
    logic [SlotCount-1:0] pending_reg, pending_next;
    logic                 in_flight_reg, in_flight_next;
    logic [SlotBits-1:0]  reply_slot_reg, reply_slot_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    logic                 go;
    logic                 emit;
    logic [SlotCount-1:0] slot_bit;
    logic [SlotCount-1:0] low_bit;
    logic [SlotBits-1:0]  low_slot;
    logic                 do_release;

    assign go = cmd_valid && (!res_valid_reg || res_ready);
    assign slot_bit = SlotCount'(1) << cmd.slot;
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_comb begin
        is_gamepad_next = is_gamepad_reg;
        reported_next = reported_reg;
        pending_next = pending_reg;
        in_flight_next = in_flight_reg;
        reply_slot_next = reply_slot_reg;
        res_next = res_reg;
        emit = 1'b0;
        cmd_pop = go;
        do_release = 1'b0;
        low_slot = '0;
        low_bit = '0;

        if (go) begin
            res_next = '0;
            res_next.slot = cmd.slot;
            res_next.last = 1'b1;
            unique case (cmd.code)
                CMD_INPUT: begin
                    if ((is_gamepad_reg & slot_bit) != '0) begin
                        emit = 1'b1;
                        res_next.kind = KIND_PAD;
                        res_next.action = cmd.action;
                        res_next.system = cmd.system;
                        res_next.dpad = cmd.dpad;
                        reported_next = reported_reg | slot_bit;
                    end
                end
                CMD_INFO_SET: begin
                    do_release = cmd.flag_a ||
                                 (((is_gamepad_reg & slot_bit) != '0) != cmd.flag_b);
                    if (do_release) begin
                        emit = (reported_reg & slot_bit) != '0;
                        res_next.kind = KIND_RELEASED;
                        reported_next = reported_reg & ~slot_bit;
                        pending_next = pending_reg & ~slot_bit;
                    end
                    if (cmd.flag_b) begin
                        is_gamepad_next = is_gamepad_reg | slot_bit;
                    end else begin
                        is_gamepad_next = is_gamepad_reg & ~slot_bit;
                    end
                    if (cmd.flag_a && cmd.flag_b) begin
                        pending_next = pending_next | slot_bit;
                    end
                end
                CMD_MARK_PAD: begin
                    is_gamepad_next = is_gamepad_reg | slot_bit;
                end
                CMD_RELEASE: begin
                    emit = (reported_reg & slot_bit) != '0;
                    res_next.kind = KIND_RELEASED;
                    is_gamepad_next = is_gamepad_reg & ~slot_bit;
                    reported_next = reported_reg & ~slot_bit;
                    pending_next = pending_reg & ~slot_bit;
                end
                CMD_ZERO_STATE: begin
                    emit = (reported_reg & slot_bit) != '0;
                    res_next.kind = KIND_PAD;
                end
                CMD_OUT_DONE: begin
                    in_flight_next = 1'b0;
                    if (cmd.flag_a && is_gamepad_reg[reply_slot_reg]) begin
                        pending_next = pending_reg | (SlotCount'(1) << reply_slot_reg);
                    end
                end
                CMD_POLL: begin
                    if (!in_flight_reg && pending_reg != '0) begin
                        low_slot = lowest_slot(pending_reg);
                        emit = 1'b1;
                        res_next.kind = KIND_ACTIVATE;
                        res_next.slot = low_slot;
                        reply_slot_next = low_slot;
                        in_flight_next = 1'b1;
                        pending_next = pending_reg & ~(SlotCount'(1) << low_slot);
                    end
                end
                CMD_DISCONNECT: begin
                    low_slot = lowest_slot(reported_reg);
                    low_bit = SlotCount'(1) << low_slot;
                    emit = reported_reg != '0;
                    res_next.kind = KIND_RELEASED;
                    res_next.slot = low_slot;
                    res_next.last = (reported_reg & ~low_bit) == '0;
                    reported_next = reported_reg & ~low_bit;
                    cmd_pop = (reported_reg & ~low_bit) == '0;
                    if (cmd_pop) begin
                        is_gamepad_next = '0;
                        reported_next = '0;
                        pending_next = '0;
                        in_flight_next = 1'b0;
                        reply_slot_next = '0;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end

        if (emit) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
        if (!emit) begin
            res_next = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_gamepad_reg <= '0;
            reported_reg <= '0;
            pending_reg <= '0;
            in_flight_reg <= 1'b0;
            reply_slot_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            is_gamepad_reg <= is_gamepad_next;
            reported_reg <= reported_next;
            pending_reg <= pending_next;
            in_flight_reg <= in_flight_next;
            reply_slot_reg <= reply_slot_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

[rtl/core/wireless_pad_receiver_slots_core.sv]
// ----------------------------------------------------------------------------
// Wireless pad receiver slots core
// Tracks eight radio slots of a wireless gamepad receiver.
// ----------------------------------------------------------------------------
// Each event transfer on the s_ side is decoded by the front end in the cycle it is
// accepted and, if it can have any effect, queued in a four-entry command queue.
// The state engine executes one command per cycle whenever the result register is
// free or being drained; a disconnect instead stays at the head of the queue and
// releases the reported slots one result at a time until none is left. Results leave
// through a single output register; m_tlast marks the final result of an event.
`default_nettype none

module wireless_pad_receiver_slots_core
    import wprs_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = 27
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // length, byte0, byte1, byte2, byte3, byte4, x_axis, y_axis, face_bits,
    // system_bits, transfer_ok
    input  wire logic [79:0] s_tdata,
    // op
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // slot, action_buttons, system_buttons, dpad
    output logic [23:0]      m_tdata,
    // kind
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    cmd_t    dec_cmd;
    logic    dec_keep;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    cmd_t    q_cmd;
    result_t res;

    assign s_tready = !q_full;

    wprs_front #(
        .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
    ) u_front (
        .op         (s_tuser),
        .length     (s_tdata[5:0]),
        .byte0      (s_tdata[13:6]),
        .byte1      (s_tdata[21:14]),
        .byte2      (s_tdata[29:22]),
        .byte3      (s_tdata[37:30]),
        .byte4      (s_tdata[45:38]),
        .x_axis     (s_tdata[53:46]),
        .y_axis     (s_tdata[61:54]),
        .face_bits  (s_tdata[69:62]),
        .system_bits(s_tdata[77:70]),
        .transfer_ok(s_tdata[78]),
        .cmd        (dec_cmd),
        .keep       (dec_keep)
    );

    wprs_cmd_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_tvalid && s_tready && dec_keep),
        .push_cmd (dec_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_valid),
        .head_cmd (q_cmd)
    );

    wprs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(q_valid),
        .cmd      (q_cmd),
        .cmd_pop  (q_pop),
        .res_valid(m_tvalid),
        .res      (res),
        .res_ready(m_tready)
    );

    assign m_tdata = {6'd0, res.dpad, res.system, res.action, res.slot};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire

[rtl/core/wprs_checker.sv]
// ----------------------------------------------------------------------------
// Wireless pad receiver slots checker
// Port-level properties of the result stream, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module wprs_checker
    import wprs_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("Stalled result transfer changed.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_PAD || m_tuser == KIND_RELEASED
            || m_tuser == KIND_ACTIVATE))
        else $error("Result kind out of range.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_PAD |-> m_tdata[17:3] == '0)
        else $error("Non-pad result carries button data.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_RELEASED |-> m_tlast)
        else $error("Only a disconnect may produce several results.");

endmodule

bind wireless_pad_receiver_slots_core wprs_checker u_wprs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

`default_nettype wire

[dv/tb_wireless_pad_receiver_slots_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wireless pad receiver slots core testbench
// Drives event transfers into the slot tracker and predicts every result
// transfer from a behavioral copy of the slot state. Directed tests cover
// length filters, info sub-operations, activation retries and disconnect.
// Random traffic follows, with stalls on both sides.
// ----------------------------------------------------------------------------

module tb_wireless_pad_receiver_slots_core;
    import wprs_pkg::*;

    localparam int MaxReportBytes = 27;
    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 64;
    localparam int RandomItems = 450;
    localparam logic [2:0] MsgUnused = 3'd7;
    localparam logic [7:0] SubUnknown = 8'h63;

    typedef struct packed {
        logic       spare;
        logic       transfer_ok;
        logic [7:0] system_bits;
        logic [7:0] face_bits;
        logic [7:0] y_axis;
        logic [7:0] x_axis;
        logic [7:0] byte4;
        logic [7:0] byte3;
        logic [7:0] byte2;
        logic [7:0] byte1;
        logic [7:0] byte0;
        logic [5:0] length;
    } slot_event_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic [SlotCount-1:0] pad_slot;
    logic [SlotCount-1:0] reported_slot;
    logic [SlotCount-1:0] activation_due;
    logic                 reply_busy;
    logic [2:0]           reply_target;
    result_t              slot_results_due[$];
    result_t              event_batch[$];

    int mismatch_count = 0;
    int events_sent = 0;
    int results_seen = 0;
    int cycle_count = 0;
    bit steady_flow = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    wireless_pad_receiver_slots_core #(
        .MAX_REPORT_BYTES(MaxReportBytes)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    function automatic int unsigned pick_gap();
        return steady_flow ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic result_t slot_result(kind_t kind, logic [2:0] slot, logic [7:0] action,
                                            logic [2:0] system, logic [3:0] dpad);
        result_t r;
        r.kind = kind;
        r.slot = slot;
        r.action = action;
        r.system = system;
        r.dpad = dpad;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void clear_tracker();
        pad_slot = '0;
        reported_slot = '0;
        activation_due = '0;
        reply_busy = 1'b0;
        reply_target = '0;
    endfunction

    function automatic void release_radio_slot(logic [2:0] slot);
        if (reported_slot[slot]) begin
            event_batch.push_back(slot_result(KIND_RELEASED, slot, 8'h00, 3'h0, 4'h0));
        end
        pad_slot[slot] = 1'b0;
        reported_slot[slot] = 1'b0;
        activation_due[slot] = 1'b0;
    endfunction

    function automatic void apply_report(slot_event_t ev);
        logic [2:0] info_slot;
        logic [2:0] pad_index;
        logic [3:0] dpad;
        logic       is_pad;
        info_slot = ev.byte1[2:0];
        pad_index = ev.byte4[2:0];
        if (!ev.transfer_ok || ev.length == 0 || ev.length > MaxReportBytes) begin
            return;
        end
        case (ev.byte0[2:0])
            MsgInput: begin
                if (ev.length >= InputMinBytes && pad_slot[pad_index]) begin
                    dpad = {ev.y_axis == AxisHigh, ev.y_axis == AxisLow,
                            ev.x_axis == AxisHigh, ev.x_axis == AxisLow};
                    event_batch.push_back(slot_result(KIND_PAD, pad_index, ev.face_bits,
                                                      ev.system_bits[2:0], dpad));
                    reported_slot[pad_index] = 1'b1;
                end
            end
            MsgInfo: begin
                if (ev.length >= InfoMinBytes) begin
                    case (ev.byte2)
                        SubNewSession, SubTypeA, SubTypeB, SubTypeC: begin
                            if (ev.length >= InfoSetMinBytes) begin
                                is_pad = (ev.byte3 == GamepadDevice);
                                if (ev.byte2 == SubNewSession || pad_slot[info_slot] != is_pad) begin
                                    release_radio_slot(info_slot);
                                end
                                pad_slot[info_slot] = is_pad;
                                if (ev.byte2 == SubNewSession && is_pad) begin
                                    activation_due[info_slot] = 1'b1;
                                end
                            end
                        end
                        SubMarkGamepad: pad_slot[info_slot] = 1'b1;
                        SubRelease: release_radio_slot(info_slot);
                        default: ;
                    endcase
                end
            end
            MsgZeroState: begin
                if (ev.length >= ZeroMinBytes && reported_slot[info_slot]) begin
                    event_batch.push_back(slot_result(KIND_PAD, info_slot, 8'h00, 3'h0, 4'h0));
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void track_slot_event(op_t op, slot_event_t ev);
        logic found;
        event_batch.delete();
        case (op)
            OP_RECEIVED: apply_report(ev);
            OP_OUT_DONE: begin
                reply_busy = 1'b0;
                if ((!ev.transfer_ok || ev.length != ReplyBytes) && pad_slot[reply_target]) begin
                    activation_due[reply_target] = 1'b1;
                end
            end
            OP_POLL: begin
                if (!reply_busy && activation_due != '0) begin
                    found = 1'b0;
                    for (int s = 0; s < SlotCount; s++) begin
                        if (!found && activation_due[s]) begin
                            found = 1'b1;
                            reply_target = 3'(s);
                        end
                    end
                    event_batch.push_back(slot_result(KIND_ACTIVATE, reply_target, 8'h00, 3'h0,
                                                      4'h0));
                    reply_busy = 1'b1;
                    activation_due[reply_target] = 1'b0;
                end
            end
            default: begin
                for (int s = 0; s < SlotCount; s++) begin
                    if (reported_slot[s]) begin
                        event_batch.push_back(slot_result(KIND_RELEASED, 3'(s), 8'h00, 3'h0,
                                                          4'h0));
                    end
                end
                clear_tracker();
            end
        endcase
        if (event_batch.size() > 0) begin
            event_batch[event_batch.size() - 1].last = 1'b1;
        end
        foreach (event_batch[i]) begin
            slot_results_due.push_back(event_batch[i]);
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    always @(posedge aclk) begin : watch_transfers
        result_t seen;
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen.kind = kind_t'(m_tuser);
                seen.slot = m_tdata[2:0];
                seen.action = m_tdata[10:3];
                seen.system = m_tdata[13:11];
                seen.dpad = m_tdata[17:14];
                seen.last = m_tlast;
                results_seen++;
                if (slot_results_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind %0d slot %0d last %0b",
                                            seen.kind, seen.slot, seen.last));
                end else begin
                    want = slot_results_due.pop_front();
                    if (seen !== want) begin
                        flag_mismatch($sformatf({"got kind %0d slot %0d act %02h sys %0d ",
                            "dpad %01h last %0b, expected kind %0d slot %0d act %02h sys %0d ",
                            "dpad %01h last %0b"}, seen.kind, seen.slot, seen.action,
                            seen.system, seen.dpad, seen.last, want.kind, want.slot,
                            want.action, want.system, want.dpad, want.last));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                track_slot_event(op_t'(s_tuser), slot_event_t'(s_tdata));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAIL wireless_pad_receiver_slots_core");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    function automatic slot_event_t noise_event();
        logic [95:0] bits;
        slot_event_t ev;
        bits = {$urandom(), $urandom(), $urandom()};
        ev = bits[79:0];
        ev.spare = 1'b0;
        return ev;
    endfunction

    function automatic slot_event_t pad_input(logic [5:0] len, logic [7:0] slot_byte,
                                              logic [7:0] x, logic [7:0] y,
                                              logic [7:0] face, logic [7:0] system);
        slot_event_t ev;
        ev = noise_event();
        ev.transfer_ok = 1'b1;
        ev.length = len;
        ev.byte0 = {5'($urandom), MsgInput};
        ev.byte4 = slot_byte;
        ev.x_axis = x;
        ev.y_axis = y;
        ev.face_bits = face;
        ev.system_bits = system;
        return ev;
    endfunction

    function automatic slot_event_t info_msg(logic [5:0] len, logic [7:0] slot_byte,
                                             logic [7:0] sub, logic [7:0] device);
        slot_event_t ev;
        ev = noise_event();
        ev.transfer_ok = 1'b1;
        ev.length = len;
        ev.byte0 = {5'($urandom), MsgInfo};
        ev.byte1 = slot_byte;
        ev.byte2 = sub;
        ev.byte3 = device;
        return ev;
    endfunction

    function automatic slot_event_t zero_msg(logic [5:0] len, logic [7:0] slot_byte);
        slot_event_t ev;
        ev = noise_event();
        ev.transfer_ok = 1'b1;
        ev.length = len;
        ev.byte0 = {5'($urandom), MsgZeroState};
        ev.byte1 = slot_byte;
        return ev;
    endfunction

    function automatic slot_event_t out_done(logic ok, logic [5:0] len);
        slot_event_t ev;
        ev = noise_event();
        ev.transfer_ok = ok;
        ev.length = len;
        return ev;
    endfunction

    function automatic logic [5:0] fit_length(logic [5:0] min_len);
        if ($urandom_range(0, 99) < 85) begin
            return 6'($urandom_range(min_len, MaxReportBytes));
        end
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] random_axis();
        case ($urandom_range(0, 2))
            0: return AxisLow;
            1: return AxisHigh;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic slot_event_t random_report();
        logic [7:0] sub_codes [6] = '{SubNewSession, SubMarkGamepad, SubRelease,
                                      SubTypeA, SubTypeB, SubTypeC};
        logic [7:0] sub;
        logic [7:0] device;
        slot_event_t ev;
        sub = ($urandom_range(0, 7) < 6) ? sub_codes[$urandom_range(0, 5)] : 8'($urandom);
        device = ($urandom_range(0, 2) != 0) ? GamepadDevice : 8'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ev = pad_input(fit_length(InputMinBytes), 8'($urandom), random_axis(),
                                       random_axis(), 8'($urandom), 8'($urandom));
            4, 5, 6, 7: ev = info_msg(fit_length(InfoMinBytes), 8'($urandom), sub, device);
            8: ev = zero_msg(fit_length(ZeroMinBytes), 8'($urandom));
            default: begin
                ev = noise_event();
                ev.transfer_ok = 1'b1;
                ev.length = fit_length(6'd1);
            end
        endcase
        if ($urandom_range(0, 15) == 0) begin
            ev.transfer_ok = 1'b0;
        end
        return ev;
    endfunction

    task automatic send_slot_event(input op_t op, input slot_event_t ev);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ev;
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        events_sent++;
    endtask

    task automatic test_quiet_events();
        send_slot_event(OP_POLL, noise_event());
        send_slot_event(OP_DISCONNECT, noise_event());
    endtask

    task automatic test_report_filters();
        slot_event_t ev;
        send_slot_event(OP_RECEIVED, info_msg(6'd4, 8'hf8, SubNewSession, GamepadDevice));
        send_slot_event(OP_RECEIVED, pad_input(6'd13, 8'h00, AxisLow, AxisLow, 8'hff, 8'hff));
        send_slot_event(OP_RECEIVED, pad_input(6'(MaxReportBytes), 8'hf8, AxisHigh, AxisHigh,
                                               8'h00, 8'h00));
        send_slot_event(OP_RECEIVED, pad_input(6'(MaxReportBytes + 1), 8'h00, AxisLow,
                                               AxisHigh, 8'h5a, 8'h01));
        send_slot_event(OP_RECEIVED, pad_input(6'd0, 8'h00, AxisLow, AxisHigh, 8'h5a, 8'h01));
        ev = pad_input(6'd63, 8'h00, AxisHigh, AxisLow, 8'h3c, 8'h02);
        ev.transfer_ok = 1'b0;
        send_slot_event(OP_RECEIVED, ev);
        send_slot_event(OP_RECEIVED, pad_input(6'd12, 8'h00, AxisHigh, AxisLow, 8'h3c, 8'h02));
        send_slot_event(OP_RECEIVED, pad_input(6'd13, 8'h03, AxisHigh, AxisLow, 8'h3c, 8'h02));
    endtask

    task automatic test_info_messages();
        slot_event_t ev;
        send_slot_event(OP_RECEIVED, info_msg(6'd3, 8'h07, SubMarkGamepad, 8'h00));
        send_slot_event(OP_RECEIVED, pad_input(6'd13, 8'hff, 8'h80, 8'h7e, 8'ha5, 8'h05));
        send_slot_event(OP_RECEIVED, zero_msg(6'd2, 8'hff));
        send_slot_event(OP_RECEIVED, zero_msg(6'd1, 8'h07));
        send_slot_event(OP_RECEIVED, info_msg(6'd4, 8'h07, SubTypeA, 8'h00));
        send_slot_event(OP_RECEIVED, info_msg(6'd3, 8'h07, SubTypeC, GamepadDevice));
        send_slot_event(OP_RECEIVED, info_msg(6'd3, 8'h00, SubRelease, 8'($urandom)));
        send_slot_event(OP_RECEIVED, info_msg(6'd4, 8'h01, SubUnknown, GamepadDevice));
        ev = zero_msg(6'd2, 8'h00);
        ev.byte0[2:0] = MsgUnused;
        send_slot_event(OP_RECEIVED, ev);
    endtask

    task automatic test_activation_retry();
        send_slot_event(OP_RECEIVED, info_msg(6'd4, 8'h02, SubNewSession, GamepadDevice));
        send_slot_event(OP_RECEIVED, info_msg(6'd4, 8'h06, SubNewSession, GamepadDevice));
        send_slot_event(OP_POLL, noise_event());
        send_slot_event(OP_POLL, noise_event());
        send_slot_event(OP_OUT_DONE, out_done(1'b0, ReplyBytes));
        send_slot_event(OP_POLL, noise_event());
        send_slot_event(OP_OUT_DONE, out_done(1'b1, ReplyBytes));
        send_slot_event(OP_POLL, noise_event());
        send_slot_event(OP_OUT_DONE, out_done(1'b1, 6'd5));
    endtask

    task automatic test_disconnect();
        send_slot_event(OP_RECEIVED, pad_input(6'd13, 8'h02, AxisLow, AxisHigh, 8'h11, 8'h04));
        send_slot_event(OP_RECEIVED, info_msg(6'd4, 8'h04, SubTypeB, GamepadDevice));
        send_slot_event(OP_RECEIVED, pad_input(6'd20, 8'h06, AxisHigh, AxisLow, 8'h80, 8'h03));
        send_slot_event(OP_DISCONNECT, noise_event());
    endtask

    task automatic test_random_traffic();
        slot_event_t ev;
        op_t         op;
        int unsigned pick;
        for (int i = 0; i < RandomItems; i++) begin
            if (i % 60 == 0) begin
                steady_flow = ($urandom_range(0, 2) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 64) begin
                op = OP_RECEIVED;
                ev = random_report();
            end else if (pick < 78) begin
                op = OP_OUT_DONE;
                ev = out_done($urandom_range(0, 7) != 0,
                              ($urandom_range(0, 3) != 0) ? ReplyBytes : 6'($urandom));
            end else if (pick < 96) begin
                op = OP_POLL;
                ev = noise_event();
            end else begin
                op = OP_DISCONNECT;
                ev = noise_event();
            end
            send_slot_event(op, ev);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_RECEIVED;
        clear_tracker();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_quiet_events();
        test_report_filters();
        test_info_messages();
        test_activation_retry();
        test_disconnect();
        test_random_traffic();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (slot_results_due.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("Sent %0d events and checked %0d results across filters, info messages,",
                 events_sent, results_seen);
        $display("activation retries, disconnects and random traffic with stalls.");
        if (mismatch_count == 0) begin
            $display("PASS wireless_pad_receiver_slots_core");
        end else begin
            $display("FAIL wireless_pad_receiver_slots_core");
        end
        $finish;
    end

endmodule
